// ===== hw/rtl/qwps_pkg.sv =====
// ----------------------------------------------------------------------------
// qwps_pkg: shared definitions for the quantile weighted price sum core
// Default sizes, result width and sequencer state codes.
// ----------------------------------------------------------------------------
package qwps_pkg;

  localparam int unsigned MAX_BIDS_DEF    = 1024;
  localparam int unsigned PRICE_BITS_DEF  = 16;
  localparam int unsigned VOLUME_BITS_DEF = 16;

  localparam int unsigned OUT_W = 42;
  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  typedef enum logic [6:0] {
    S_LOAD   = 7'b0000001,
    S_FETCH  = 7'b0000010,
    S_LATCH  = 7'b0000100,
    S_SCAN   = 7'b0001000,
    S_DECIDE = 7'b0010000,
    S_ACC    = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

endpackage

// ===== hw/rtl/qwps_ram.sv =====
// ----------------------------------------------------------------------------
// qwps_ram: single-port RAM
// One address for write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module qwps_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/quantile_weighted_price_sum_core.sv =====
// ----------------------------------------------------------------------------
// quantile_weighted_price_sum_core
// Collects a set of bids, then sums price * volume over every bid whose
// strictly-lower-priced volume exceeds a quarter of the set's total volume.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+--------------------------
//   bid      | in        | bid_valid_i/bid_ready_o | bid_price_i, bid_volume_i,
//            |           |                         | last_bid_i
//   sum      | out       | sum_valid_o/sum_ready_i | weighted_sum_o
//
// Bids load one per cycle. After the last bid of a set of N stored bids the
// evaluation runs bid by bid: each bid is fetched, then all N bids are
// scanned through the single read port of the bid RAM.
// The block takes no bid during evaluation; a finished sum waits in its
// output register while the next set loads, and the done step stalls while
// that register is still full.
// Reset clears the sequencer, counters and output valid; the bid RAM is not
// cleared since only entries written in the current set are read.
// ----------------------------------------------------------------------------
module quantile_weighted_price_sum_core #(
  parameter int unsigned MAX_BIDS    = qwps_pkg::MAX_BIDS_DEF,
  parameter int unsigned PRICE_BITS  = qwps_pkg::PRICE_BITS_DEF,
  parameter int unsigned VOLUME_BITS = qwps_pkg::VOLUME_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        bid_valid_i,
  output logic                        bid_ready_o,
  input  logic [PRICE_BITS-1:0]       bid_price_i,
  input  logic [VOLUME_BITS-1:0]      bid_volume_i,
  input  logic                        last_bid_i,
  output logic                        sum_valid_o,
  input  logic                        sum_ready_i,
  output logic [qwps_pkg::OUT_W-1:0]  weighted_sum_o
);

  localparam int unsigned AW    = (MAX_BIDS > 1) ? $clog2(MAX_BIDS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_BIDS + 1);
  localparam int unsigned TOT_W = VOLUME_BITS + AW;
  localparam int unsigned PV_W  = PRICE_BITS + VOLUME_BITS;
  localparam int unsigned OUT_W = qwps_pkg::OUT_W;
  localparam int unsigned SUM_W = (PV_W + 1 > OUT_W + 1) ? PV_W + 1 : OUT_W + 1;

  qwps_pkg::state_e state_q, state_d;

  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [TOT_W-1:0]       tot_q, tot_d;
  logic [CNT_W-1:0]       idx_q, idx_d;
  logic [CNT_W-1:0]       jdx_q, jdx_d;
  logic                   rd_vld_q, rd_vld_d;
  logic [PRICE_BITS-1:0]  cur_price_q, cur_price_d;
  logic [VOLUME_BITS-1:0] cur_vol_q, cur_vol_d;
  logic [TOT_W-1:0]       lower_q, lower_d;
  logic                   qual_q, qual_d;
  logic [PV_W-1:0]        prod_q, prod_d;
  logic [OUT_W-1:0]       acc_q, acc_d;
  logic                   out_valid_q, out_valid_d;
  logic [OUT_W-1:0]       out_q, out_d;

  logic                   ram_we;
  logic [AW-1:0]          ram_addr;
  logic [PV_W-1:0]        ram_wdata;
  logic [PV_W-1:0]        ram_rdata;
  logic [PRICE_BITS-1:0]  rd_price;
  logic [VOLUME_BITS-1:0] rd_vol;

  logic                   bid_acc;
  logic [CNT_W-1:0]       idx_inc;
  logic [SUM_W-1:0]       sum_ext;

  assign bid_ready_o = (state_q == qwps_pkg::S_LOAD);
  assign bid_acc     = bid_valid_i & bid_ready_o;
  assign rd_price    = ram_rdata[PV_W-1:VOLUME_BITS];
  assign rd_vol      = ram_rdata[VOLUME_BITS-1:0];
  assign idx_inc     = idx_q + CNT_W'(1);
  assign sum_ext     = SUM_W'(acc_q) + SUM_W'(prod_q);

  qwps_ram #(
    .WIDTH(PV_W),
    .DEPTH(MAX_BIDS)
  ) u_bid_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    tot_d       = tot_q;
    idx_d       = idx_q;
    jdx_d       = jdx_q;
    rd_vld_d    = 1'b0;
    cur_price_d = cur_price_q;
    cur_vol_d   = cur_vol_q;
    lower_d     = lower_q;
    qual_d      = qual_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_addr    = cnt_q[AW-1:0];
    ram_wdata   = {bid_price_i, bid_volume_i};

    if (out_valid_q && sum_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      qwps_pkg::S_LOAD: begin
        if (bid_acc) begin
          // A bid beyond the store's capacity is dropped.
          if (cnt_q < CNT_W'(MAX_BIDS)) begin
            ram_we = 1'b1;
            cnt_d  = cnt_q + CNT_W'(1);
            tot_d  = tot_q + TOT_W'(bid_volume_i);
          end
          if (last_bid_i) begin
            idx_d   = '0;
            acc_d   = '0;
            state_d = qwps_pkg::S_FETCH;
          end
        end
      end
      qwps_pkg::S_FETCH: begin
        ram_addr = idx_q[AW-1:0];
        state_d  = qwps_pkg::S_LATCH;
      end
      qwps_pkg::S_LATCH: begin
        cur_price_d = rd_price;
        cur_vol_d   = rd_vol;
        jdx_d       = '0;
        lower_d     = '0;
        state_d     = qwps_pkg::S_SCAN;
      end
      qwps_pkg::S_SCAN: begin
        // Reads are issued in the cycle before the compare that consumes them.
        if (jdx_q < cnt_q) begin
          ram_addr = jdx_q[AW-1:0];
          jdx_d    = jdx_q + CNT_W'(1);
          rd_vld_d = 1'b1;
        end
        if (rd_vld_q && (rd_price < cur_price_q)) begin
          lower_d = lower_q + TOT_W'(rd_vol);
        end
        if ((jdx_q == cnt_q) && !rd_vld_q) begin
          state_d = qwps_pkg::S_DECIDE;
        end
      end
      qwps_pkg::S_DECIDE: begin
        qual_d  = ({2'b00, tot_q} < {lower_q, 2'b00});
        prod_d  = PV_W'(cur_price_q) * PV_W'(cur_vol_q);
        state_d = qwps_pkg::S_ACC;
      end
      qwps_pkg::S_ACC: begin
        if (qual_q) begin
          acc_d = (sum_ext > SUM_W'(qwps_pkg::OUT_MAX)) ? qwps_pkg::OUT_MAX
                                                        : sum_ext[OUT_W-1:0];
        end
        idx_d   = idx_inc;
        state_d = (idx_inc == cnt_q) ? qwps_pkg::S_DONE : qwps_pkg::S_FETCH;
      end
      qwps_pkg::S_DONE: begin
        // Hold the sum until the output register is free.
        if (!out_valid_q || sum_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = acc_q;
          cnt_d       = '0;
          tot_d       = '0;
          state_d     = qwps_pkg::S_LOAD;
        end
      end
      default: begin
        state_d = qwps_pkg::S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= qwps_pkg::S_LOAD;
      cnt_q       <= '0;
      tot_q       <= '0;
      idx_q       <= '0;
      jdx_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      tot_q       <= tot_d;
      idx_q       <= idx_d;
      jdx_q       <= jdx_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_price_q <= cur_price_d;
    cur_vol_q   <= cur_vol_d;
    lower_q     <= lower_d;
    qual_q      <= qual_d;
    prod_q      <= prod_d;
    acc_q       <= acc_d;
    out_q       <= out_d;
  end

  assign sum_valid_o    = out_valid_q;
  assign weighted_sum_o = out_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_BIDS))
    else $error("bid count exceeds store capacity");

  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bid_acc && last_bid_i) |=> (state_q == qwps_pkg::S_FETCH) && (cnt_q != '0))
    else $error("last word did not start evaluation of a nonempty set");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == qwps_pkg::S_SCAN) |-> (jdx_q <= cnt_q) && (idx_q < cnt_q))
    else $error("scan index beyond stored set");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == qwps_pkg::S_DONE))
    else $error("result valid raised outside the done step");

  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == qwps_pkg::S_DONE) && (state_d == qwps_pkg::S_LOAD))
      |=> (cnt_q == '0) && (tot_q == '0) && out_valid_q)
    else $error("set state not cleared after result");

endmodule
